@@ hw/rtl/rmsc_pkg.sv @@
package rmsc_pkg;

    localparam int unsigned BOUND_ENTRIES = 64;

    // error codes as reported on o_error_code
    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW    = 2'd1;
    localparam logic [1:0] ERR_ZERO_PERIOD = 2'd2;
    localparam logic [1:0] ERR_SATURATED   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_GCD,
        S_LDIV,
        S_MUL,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic gcd_step;
        logic ldiv_init;
        logic ldiv_step;
        logic mul_step;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic zero_period;
        logic div_done;
        logic gcd_done;
        logic ldiv_done;
        logic mul_done;
    } t_status;

    function automatic logic [16:0] bound_lookup(input logic [5:0] idx);
        logic [16:0] v;
        case (idx)
            6'd0: v = 17'd65536;  6'd1: v = 17'd54292;  6'd2: v = 17'd51103;
            6'd3: v = 17'd49600;  6'd4: v = 17'd48725;  6'd5: v = 17'd48154;
            6'd6: v = 17'd47751;  6'd7: v = 17'd47452;  6'd8: v = 17'd47221;
            6'd9: v = 17'd47037;  6'd10: v = 17'd46888; 6'd11: v = 17'd46764;
            6'd12: v = 17'd46659; 6'd13: v = 17'd46569; 6'd14: v = 17'd46492;
            6'd15: v = 17'd46424; 6'd16: v = 17'd46365; 6'd17: v = 17'd46312;
            6'd18: v = 17'd46265; 6'd19: v = 17'd46222; 6'd20: v = 17'd46184;
            6'd21: v = 17'd46149; 6'd22: v = 17'd46118; 6'd23: v = 17'd46088;
            6'd24: v = 17'd46062; 6'd25: v = 17'd46037; 6'd26: v = 17'd46014;
            6'd27: v = 17'd45993; 6'd28: v = 17'd45973; 6'd29: v = 17'd45955;
            6'd30: v = 17'd45938; 6'd31: v = 17'd45922; 6'd32: v = 17'd45907;
            6'd33: v = 17'd45892; 6'd34: v = 17'd45879; 6'd35: v = 17'd45866;
            6'd36: v = 17'd45854; 6'd37: v = 17'd45843; 6'd38: v = 17'd45832;
            6'd39: v = 17'd45822; 6'd40: v = 17'd45812; 6'd41: v = 17'd45803;
            6'd42: v = 17'd45794; 6'd43: v = 17'd45786; 6'd44: v = 17'd45778;
            6'd45: v = 17'd45770; 6'd46: v = 17'd45763; 6'd47: v = 17'd45756;
            6'd48: v = 17'd45749; 6'd49: v = 17'd45742; 6'd50: v = 17'd45736;
            6'd51: v = 17'd45730; 6'd52: v = 17'd45724; 6'd53: v = 17'd45719;
            6'd54: v = 17'd45714; 6'd55: v = 17'd45708; 6'd56: v = 17'd45703;
            6'd57: v = 17'd45699; 6'd58: v = 17'd45694; 6'd59: v = 17'd45689;
            6'd60: v = 17'd45685; 6'd61: v = 17'd45681; 6'd62: v = 17'd45677;
            default: v = 17'd45673;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/rmsc_ctrl.sv @@
module rmsc_ctrl
    import rmsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_status.zero_period) begin
                    n_state = S_DONE;
                end else if (i_status.div_done) begin
                    n_state = S_GCD;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_GCD: begin
                if (i_status.gcd_done) begin
                    o_cmd.ldiv_init = 1'b1;
                    n_state = S_LDIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_LDIV: begin
                if (i_status.ldiv_done) begin
                    n_state = S_MUL;
                end else begin
                    o_cmd.ldiv_step = 1'b1;
                end
            end
            S_MUL: begin
                if (i_status.mul_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/rmsc_dp.sv @@
module rmsc_dp
    import rmsc_pkg::*;
#(
    parameter int unsigned MAX_TASKS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [15:0] i_wcet,
    input  logic [15:0] i_period,
    input  logic        i_last_task,
    output t_status     o_status,
    output logic        o_valid,
    output logic [31:0] o_utilization,
    output logic [31:0] o_hyperperiod,
    output logic [15:0] o_set_size,
    output logic [16:0] o_rm_bound,
    output logic        o_verdict,
    output logic [1:0]  o_error_code
);

    localparam int unsigned CAP_RAW = (MAX_TASKS < BOUND_ENTRIES) ? MAX_TASKS : BOUND_ENTRIES;
    localparam logic [15:0] CAP = 16'(CAP_RAW);

    // set state
    logic [31:0] r_util, r_lcm;
    logic [15:0] r_count;
    logic [2:0]  r_err;

    // latched request
    logic [15:0] r_period;
    logic        r_last;

    // restoring divider for wcet<<16 / period: 32 bit dividend
    logic [31:0] r_dq;
    logic [16:0] r_drem;
    logic [5:0]  r_dcnt;

    // binary gcd, one shift or halved difference a cycle
    logic [31:0] r_ga, r_gb;
    logic [3:0]  r_gsh;

    // lcm / g divider
    logic [31:0] r_lq, r_lrem;
    logic [5:0]  r_lcnt;

    // shift-add multiply lcm/g * period, 64 bit product
    logic [63:0] r_prod;
    logic [31:0] r_mcand;
    logic [15:0] r_mplier;
    logic [4:0]  r_mcnt;

    logic [17:0] w_dtrial;
    logic [32:0] w_ltrial;
    logic [31:0] w_gdiff;
    logic [31:0] w_gval;
    logic [32:0] w_usum;
    logic [15:0] w_bidx;
    logic [16:0] w_bound;

    assign w_gdiff  = (r_ga >= r_gb) ? (r_ga - r_gb) : (r_gb - r_ga);
    assign w_gval   = r_gb << r_gsh;
    assign w_dtrial = {r_drem, r_dq[31]} - {2'b00, r_period};
    assign w_ltrial = {r_lrem, r_lq[31]} - {1'b0, w_gval};
    assign w_usum   = {1'b0, r_util} + {1'b0, r_dq};

    assign o_status.zero_period = (r_period == 16'd0);
    assign o_status.div_done    = (r_dcnt == 6'd32);
    assign o_status.gcd_done    = (r_ga == 32'd0);
    assign o_status.ldiv_done   = (r_lcnt == 6'd32);
    assign o_status.mul_done    = (r_mcnt == 5'd16);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_period <= i_period;
            r_last   <= i_last_task;
            r_dq     <= {i_wcet, 16'd0};
            r_drem   <= '0;
            r_dcnt   <= '0;
            r_ga     <= r_lcm;
            r_gb     <= {16'd0, i_period};
            r_gsh    <= '0;
            r_mcnt   <= '0;
        end
        if (i_cmd.div_step) begin
            if (!w_dtrial[17]) begin
                r_drem <= w_dtrial[16:0];
                r_dq   <= {r_dq[30:0], 1'b1};
            end else begin
                r_drem <= {r_drem[15:0], r_dq[31]};
                r_dq   <= {r_dq[30:0], 1'b0};
            end
            r_dcnt <= r_dcnt + 6'd1;
        end
        if (i_cmd.gcd_step) begin
            // common factors of two are counted in r_gsh, gcd is r_gb << r_gsh at the end
            if (!r_ga[0] && !r_gb[0]) begin
                r_ga  <= {1'b0, r_ga[31:1]};
                r_gb  <= {1'b0, r_gb[31:1]};
                r_gsh <= r_gsh + 4'd1;
            end else if (!r_ga[0]) begin
                r_ga <= {1'b0, r_ga[31:1]};
            end else if (!r_gb[0]) begin
                r_gb <= {1'b0, r_gb[31:1]};
            end else begin
                r_ga <= {1'b0, w_gdiff[31:1]};
                if (r_ga < r_gb) begin
                    r_gb <= r_ga;
                end
            end
        end
        if (i_cmd.ldiv_init) begin
            r_lq   <= r_lcm;
            r_lrem <= '0;
            r_lcnt <= '0;
        end
        if (i_cmd.ldiv_step) begin
            if (!w_ltrial[32]) begin
                r_lrem <= w_ltrial[31:0];
                r_lq   <= {r_lq[30:0], 1'b1};
            end else begin
                r_lrem <= {r_lrem[30:0], r_lq[31]};
                r_lq   <= {r_lq[30:0], 1'b0};
            end
            r_lcnt <= r_lcnt + 6'd1;
            if (r_lcnt == 6'd31) begin
                r_prod   <= '0;
                r_mplier <= r_period;
            end
        end
        if (i_cmd.mul_step) begin
            if (r_mcnt == 5'd0) begin
                r_mcand <= r_lq;
                r_prod  <= r_mplier[0] ? {32'd0, r_lq} : 64'd0;
            end else if (r_mplier[0]) begin
                r_prod <= r_prod + ({32'd0, r_mcand} << r_mcnt[3:0]);
            end
            r_mplier <= {1'b0, r_mplier[15:1]};
            r_mcnt   <= r_mcnt + 5'd1;
        end
    end

    assign w_bidx  = (r_count > CAP) ? CAP : ((r_count == 16'd0) ? 16'd1 : r_count);
    assign w_bound = bound_lookup(6'(w_bidx - 16'd1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_util  <= '0;
            r_lcm   <= 32'd1;
            r_count <= '0;
            r_err   <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cmd.load && r_count != 16'hFFFF) begin
                r_count <= r_count + 16'd1;
            end
            if (i_cmd.finish) begin
                logic [31:0] v_util, v_lcm;
                logic [2:0]  v_err;
                v_util = r_util;
                v_lcm  = r_lcm;
                v_err  = r_err;
                if (r_period == 16'd0) begin
                    v_err[1] = 1'b1;
                end else begin
                    if (w_usum[32]) begin
                        v_util = 32'hFFFFFFFF;
                        v_err[2] = 1'b1;
                    end else begin
                        v_util = w_usum[31:0];
                    end
                    if (r_prod[63:32] != 32'd0) begin
                        v_lcm = 32'd0;
                        v_err[0] = 1'b1;
                    end else begin
                        v_lcm = r_prod[31:0];
                    end
                end
                if (r_last) begin
                    o_valid       <= 1'b1;
                    o_utilization <= v_util;
                    o_hyperperiod <= v_lcm;
                    o_set_size    <= r_count;
                    o_rm_bound    <= w_bound;
                    o_verdict     <= (v_util > {15'd0, w_bound});
                    o_error_code  <= v_err[1] ? ERR_ZERO_PERIOD : (v_err[0] ? ERR_OVERFLOW :
                                     (v_err[2] ? ERR_SATURATED : ERR_NONE));
                    r_util  <= '0;
                    r_lcm   <= 32'd1;
                    r_count <= '0;
                    r_err   <= '0;
                end else begin
                    r_util <= v_util;
                    r_lcm  <= v_lcm;
                    r_err  <= v_err;
                end
            end
        end
    end

endmodule

@@ hw/rtl/rm_schedulability_check_core.sv @@
// after a request is taken, busy stays high through these steps in order: the utilization
// divider, the binary gcd of one shift or halved difference a cycle, the lcm divider, the
// multiply and the finish state; a zero period goes from the divider state straight to finish
// one request at a time: the next is taken once busy falls
// after the last task of a set, o_valid is high for one cycle, the first with busy low; no stall
// synchronous active-low reset clears the set state and returns to idle
module rm_schedulability_check_core
    import rmsc_pkg::*;
#(
    parameter int unsigned MAX_TASKS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_wcet,
    input  logic [15:0] i_period,
    input  logic        i_last_task,
    output logic        o_valid,
    output logic [31:0] o_utilization,
    output logic [31:0] o_hyperperiod,
    output logic [15:0] o_set_size,
    output logic [16:0] o_rm_bound,
    output logic        o_verdict,
    output logic [1:0]  o_error_code
);

    // command and status between controller and datapath
    t_cmd    w_cmd;
    t_status w_status;

    rmsc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    rmsc_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_wcet        (i_wcet),
        .i_period      (i_period),
        .i_last_task   (i_last_task),
        .o_status      (w_status),
        .o_valid       (o_valid),
        .o_utilization (o_utilization),
        .o_hyperperiod (o_hyperperiod),
        .o_set_size    (o_set_size),
        .o_rm_bound    (o_rm_bound),
        .o_verdict     (o_verdict),
        .o_error_code  (o_error_code)
    );

endmodule
